>>> rtl/sli_pkg.sv
// Shared types and codes for the sorted list engine.
`default_nettype none
package sli_pkg;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_DELETE = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] value;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic [4:0]         entry_count;
      logic signed [31:0] smallest;
      logic               smallest_valid;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic start_ins;
      logic start_del;
      logic shift_up;
      logic shift_down;
      logic put;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_delete;
      logic count_zero;
      logic full;
      logic rd_ge;
      logic idx_zero;
      logic idx_last;
   } stat_type;

endpackage
`default_nettype wire

>>> rtl/sli_datapath.sv
// Datapath: entry memory, count, scan index, smallest-value tracking and result register.
`default_nettype none
module sli_datapath #(
   parameter int CAPACITY = 16,
   parameter int CW       = 5,
   parameter int AW       = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sli_pkg::req_item_type req_data,
   input  wire sli_pkg::cmd_type      cmd,
   output sli_pkg::stat_type          stat,
   output sli_pkg::rsp_item_type      rsp_data
);

   logic [31:0]           mem [CAPACITY];

   logic                  kind_ff,  kind_in;
   logic signed [31:0]    key_ff,   key_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff,   idx_in;
   logic                  found_ff, found_in;
   logic [31:0]           rdata_ff;
   logic signed [31:0]    smallest_ff, smallest_in;
   sli_pkg::rsp_item_type rsp_ff,   rsp_in;

   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [CW-1:0]         wr_idx;
   logic [AW-1:0]         wr_addr;
   logic [31:0]           wr_data;
   logic                  full;
   logic                  idx_last;
   logic [CW+4:0]         count_wide;

   assign full     = (count_ff == CW'(CAPACITY));
   assign idx_last = (CW'(idx_ff + CW'(1)) == count_ff);

   always_comb begin
      stat.is_delete  = (kind_ff == sli_pkg::REQ_DELETE);
      stat.count_zero = (count_ff == '0);
      stat.full       = full;
      stat.rd_ge      = ($signed(rdata_ff) >= key_ff);
      stat.idx_zero   = (idx_ff == '0);
      stat.idx_last   = idx_last;
   end

   // scan index and capture
   always_comb begin
      kind_in  = kind_ff;
      key_in   = key_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      rd_en    = 1'b0;
      if (cmd.capture) begin
         kind_in  = req_data.req_type;
         key_in   = req_data.value;
         // a delete on an empty list skips the scan, so the match flag starts clear here
         found_in = 1'b0;
      end
      if (cmd.start_ins) begin
         idx_in = CW'(count_ff - CW'(1));
         rd_en  = (count_ff != '0);
      end
      if (cmd.start_del) begin
         idx_in   = '0;
         found_in = 1'b0;
         rd_en    = 1'b1;
      end
      if (cmd.shift_up) begin
         idx_in = CW'(idx_ff - CW'(1));
         rd_en  = (idx_ff != '0);
      end
      if (cmd.shift_down) begin
         idx_in   = CW'(idx_ff + CW'(1));
         found_in = found_ff | (rdata_ff == key_ff);
         rd_en    = !idx_last;
      end
   end

   assign rd_addr = idx_in[AW-1:0];

   // memory write: shift up for insert, shift down behind a match for delete, put of the key for insert
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = CW'(idx_ff + CW'(1));
      wr_data = rdata_ff;
      if (cmd.shift_up) begin
         wr_en = 1'b1;
      end else if (cmd.shift_down && found_ff) begin
         wr_en  = 1'b1;
         wr_idx = CW'(idx_ff - CW'(1));
      end else if (cmd.put) begin
         wr_en   = 1'b1;
         wr_data = key_ff;
      end
   end

   assign wr_addr = wr_idx[AW-1:0];

   // slot zero is mirrored so the smallest value needs no extra read
   always_comb begin
      smallest_in = smallest_ff;
      if (wr_en && (wr_addr == '0)) begin
         smallest_in = $signed(wr_data);
      end
   end

   always_comb begin
      count_in = count_ff;
      rsp_in   = rsp_ff;
      if (cmd.finish) begin
         if (kind_ff == sli_pkg::REQ_INSERT) begin
            rsp_in.status = full ? sli_pkg::ST_FULL : sli_pkg::ST_DONE;
            if (!full) begin
               count_in = CW'(count_ff + CW'(1));
            end
         end else begin
            rsp_in.status = found_ff ? sli_pkg::ST_DONE : sli_pkg::ST_NOT_FOUND;
            if (found_ff) begin
               count_in = CW'(count_ff - CW'(1));
            end
         end
         rsp_in.entry_count    = count_wide[4:0];
         rsp_in.smallest_valid = (count_in != '0);
         rsp_in.smallest       = (count_in != '0) ? smallest_ff : 32'sd0;
      end
   end

   assign count_wide = {5'd0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      smallest_ff <= smallest_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rsp_data = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_put_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> !full)
      else $error("insert written into a full list");

   a_del_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && kind_ff == sli_pkg::REQ_DELETE && found_ff)
         |=> count_ff == CW'($past(count_ff) - CW'(1)))
      else $error("delete of a found entry did not drop the count");

endmodule
`default_nettype wire

>>> rtl/sli_controller.sv
// Controller: sequences capture, memory scan, final write and result handoff.
`default_nettype none
module sli_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire sli_pkg::stat_type stat,
   output sli_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      IDLE,
      START,
      STEP_INS,
      STEP_DEL,
      PUT,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = START;
            end
         end
         START: begin
            if (!stat.is_delete) begin
               if (stat.full) begin
                  state_in = FINISH;
               end else begin
                  cmd.start_ins = 1'b1;
                  state_in      = stat.count_zero ? PUT : STEP_INS;
               end
            end else if (stat.count_zero) begin
               state_in = FINISH;
            end else begin
               cmd.start_del = 1'b1;
               state_in      = STEP_DEL;
            end
         end
         STEP_INS: begin
            // walk down from the top, moving entries not smaller than the key up one slot
            if (stat.rd_ge) begin
               cmd.shift_up = 1'b1;
               if (stat.idx_zero) begin
                  state_in = PUT;
               end
            end else begin
               state_in = PUT;
            end
         end
         STEP_DEL: begin
            cmd.shift_down = 1'b1;
            if (stat.idx_last) begin
               state_in = FINISH;
            end
         end
         PUT: begin
            cmd.put  = 1'b1;
            state_in = FINISH;
         end
         FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == FINISH))
      else $error("result raised outside the finish step");

   a_shift_up_insert: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_up |-> (!stat.is_delete && !stat.count_zero))
      else $error("upward shift outside an insert");

   a_del_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STEP_DEL) |-> (stat.is_delete && !stat.count_zero))
      else $error("delete scan on an empty list");

endmodule
`default_nettype wire

>>> rtl/sorted_list_insert_delete.sv
// Sorted list engine holding up to CAPACITY signed 32-bit values in ascending order in a
// memory with one read and one write port. Requests are taken one at a time; each gives
// exactly one result with status, entry count and the smallest held value. An insert scans
// down from the top entry, moving each entry that is not smaller than the key up one slot;
// a full-list insert skips the scan. A delete scans the whole list once, closing the gap
// behind the first match; on an empty list it skips the scan. The memory scan handles one
// entry per cycle. The result register lets the next request be accepted while a result is
// still stalled. No clearing pass is needed after reset.
`default_nettype none
module sorted_list_insert_delete #(
   parameter int CAPACITY = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sli_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sli_pkg::rsp_item_type      rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   sli_pkg::cmd_type  cmd;
   sli_pkg::stat_type stat;

   sli_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sli_datapath #(
      .CAPACITY (CAPACITY),
      .CW       (CW),
      .AW       (AW)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
